// File: hdl/qbvg_pkg.sv
// ----------------------------------------------------------------------------
// qbvg_pkg: shared definitions of the quad batch vertex generator
// Sizes, codes and the transaction and job structures used by all modules.
// ----------------------------------------------------------------------------
package qbvg_pkg;

  // Number of texture slots in one batch, and the quad limit of a batch.
  localparam int SLOT_COUNT = 32;
  localparam int MAX_QUADS  = 4096;

  // Slot table index width and the width of a fill count (0 .. SLOT_COUNT).
  localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SLOT_W     = $clog2(SLOT_COUNT + 1);

  // Index count: six per quad, saturating at MAX_QUADS * 6 and at the field.
  localparam int IDX_W       = 15;
  localparam int IDX_CAP_RAW = MAX_QUADS * 6;
  localparam int IDX_CAP     = (IDX_CAP_RAW > 32767) ? 32767 : IDX_CAP_RAW;
  localparam int IDX_STEP    = 6;

  // Job queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [SLOT_IDX_W-1:0] slot_idx_t;
  typedef logic [SLOT_W-1:0]     slot_cnt_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [QPTR_W-1:0]     qptr_t;
  typedef logic [QCNT_W-1:0]     qcnt_t;

  // Command codes of an input transaction.
  localparam logic CMD_DRAW  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_VERTEX = 2'd0,
    KIND_BIND   = 2'd1,
    KIND_DRAW   = 2'd2
  } kind_t;

  // Input transaction.
  typedef struct packed {
    logic              cmd;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] size_x;
    logic signed [31:0] size_y;
    logic [31:0]        color_rgba;
    logic [31:0]        tex_handle;
  } quad_t;

  // Result transaction.
  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic               tex_u;
    logic               tex_v;
    logic [5:0]         slot;
    logic [31:0]        out_color;
    logic [31:0]        bound_texture;
    idx_t               batch_indices;
    logic               last;
  } result_t;

  // Work handed from the front to the back: either a flush or one quad.
  typedef struct packed {
    logic               is_flush;
    logic               last;
    slot_cnt_t          nbinds;
    idx_t               total;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] size_x;
    logic signed [31:0] size_y;
    logic [31:0]        color;
    logic [5:0]         slot;
  } job_t;

  // Status of the back as seen by the front, with its slot table read address.
  typedef struct packed {
    logic      busy;
    slot_idx_t rd_addr;
  } back_stat_t;

endpackage

// File: hdl/qbvg_queue.sv
// ----------------------------------------------------------------------------
// qbvg_queue: job queue between front and back
// A short first-in first-out buffer of jobs, so that each side stalls alone.
// ----------------------------------------------------------------------------
module qbvg_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  qbvg_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output qbvg_pkg::job_t  pop_job,
  output logic            empty
);

  qbvg_pkg::job_t  entries [qbvg_pkg::QUEUE_DEPTH];
  qbvg_pkg::qptr_t wr_ptr;
  qbvg_pkg::qptr_t rd_ptr;
  qbvg_pkg::qcnt_t count;

  assign full    = (count == qbvg_pkg::qcnt_t'(qbvg_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_job = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == qbvg_pkg::qptr_t'(qbvg_pkg::QUEUE_DEPTH - 1)) ? '0
                  : qbvg_pkg::qptr_t'(wr_ptr + 1'b1);
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == qbvg_pkg::qptr_t'(qbvg_pkg::QUEUE_DEPTH - 1)) ? '0
                  : qbvg_pkg::qptr_t'(rd_ptr + 1'b1);
      end
      if ((push && !full) && !(pop && !empty)) begin
        count <= qbvg_pkg::qcnt_t'(count + 1'b1);
      end else if (!(push && !full) && (pop && !empty)) begin
        count <= qbvg_pkg::qcnt_t'(count - 1'b1);
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// File: hdl/qbvg_front.sv
// ----------------------------------------------------------------------------
// qbvg_front: request intake and texture slot management
// Accepts quad and flush transactions, searches and appends the slot table,
// keeps the index count and queues flush and quad jobs for the back.
// ----------------------------------------------------------------------------
module qbvg_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 quad_valid,
  output logic                 quad_ready,
  input  qbvg_pkg::quad_t      quad,
  output logic                 push,
  output qbvg_pkg::job_t       push_job,
  input  logic                 full,
  input  logic                 empty,
  input  qbvg_pkg::back_stat_t back_stat,
  output logic [31:0]          table_data
);

  typedef enum logic [4:0] {
    F_IDLE  = 5'b00001,
    F_CLASS = 5'b00010,
    F_FLUSH = 5'b00100,
    F_DRAIN = 5'b01000,
    F_QUAD  = 5'b10000
  } front_state_t;

  front_state_t                   state;
  qbvg_pkg::quad_t                item;
  logic [qbvg_pkg::SLOT_COUNT-1:0] match;
  logic [qbvg_pkg::SLOT_COUNT-1:0] match_now;
  logic [31:0]                    slot_tex [qbvg_pkg::SLOT_COUNT];
  qbvg_pkg::slot_cnt_t            slots_used;
  qbvg_pkg::idx_t                 index_total;
  qbvg_pkg::idx_t                 index_inc;
  logic [5:0]                     slot_sel;
  logic                           flush_last;
  qbvg_pkg::slot_idx_t            enc;
  logic                           found;
  logic                           textured;
  logic                           table_full;

  assign quad_ready = (state == F_IDLE);
  assign table_data = slot_tex[back_stat.rd_addr];

  // Compare the incoming id against every filled slot; registered below.
  always_comb begin
    for (int i = 0; i < qbvg_pkg::SLOT_COUNT; i++) begin
      match_now[i] = (slot_tex[i] == quad.tex_handle) &&
                     (qbvg_pkg::slot_cnt_t'(i) < slots_used);
    end
  end

  // Ids in the table are unique, so the match vector has at most one bit set.
  always_comb begin
    enc = '0;
    for (int i = 0; i < qbvg_pkg::SLOT_COUNT; i++) begin
      if (match[i]) begin
        enc = enc | qbvg_pkg::slot_idx_t'(i);
      end
    end
  end

  assign found      = |match;
  assign textured   = (item.tex_handle != '0);
  assign table_full = (slots_used >= qbvg_pkg::slot_cnt_t'(qbvg_pkg::SLOT_COUNT));
  assign index_inc  = (index_total > qbvg_pkg::idx_t'(qbvg_pkg::IDX_CAP - qbvg_pkg::IDX_STEP))
                      ? qbvg_pkg::idx_t'(qbvg_pkg::IDX_CAP)
                      : qbvg_pkg::idx_t'(index_total + qbvg_pkg::idx_t'(qbvg_pkg::IDX_STEP));

  // Sequencer and batch state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= F_IDLE;
      slots_used  <= '0;
      index_total <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (quad_valid) begin
            item  <= quad;
            match <= match_now;
            state <= F_CLASS;
          end
        end
        F_CLASS: begin
          if (item.cmd == qbvg_pkg::CMD_FLUSH) begin
            flush_last <= 1'b1;
            state      <= F_FLUSH;
          end else if (textured && !found && table_full) begin
            flush_last <= 1'b0;
            state      <= F_FLUSH;
          end else begin
            if (!textured) begin
              slot_sel <= '0;
            end else if (found) begin
              slot_sel <= 6'(qbvg_pkg::slot_cnt_t'(enc) + 1'b1);
            end else begin
              slot_tex[slots_used[qbvg_pkg::SLOT_IDX_W-1:0]] <= item.tex_handle;
              slots_used <= qbvg_pkg::slot_cnt_t'(slots_used + 1'b1);
              slot_sel   <= 6'(slots_used + 1'b1);
            end
            index_total <= index_inc;
            state       <= F_QUAD;
          end
        end
        F_FLUSH: begin
          if (!full) begin
            state <= F_DRAIN;
          end
        end
        F_DRAIN: begin
          // The back reads the table for its binds; clear only once it is done.
          if (empty && !back_stat.busy) begin
            if (flush_last) begin
              slots_used  <= '0;
              index_total <= '0;
              state       <= F_IDLE;
            end else begin
              slot_tex[0] <= item.tex_handle;
              slots_used  <= qbvg_pkg::slot_cnt_t'(1);
              slot_sel    <= 6'd1;
              index_total <= qbvg_pkg::idx_t'(qbvg_pkg::IDX_STEP);
              state       <= F_QUAD;
            end
          end
        end
        F_QUAD: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  // Job presented to the queue.
  assign push = ((state == F_FLUSH) || (state == F_QUAD)) && !full;

  always_comb begin
    push_job = '0;
    if (state == F_FLUSH) begin
      push_job.is_flush = 1'b1;
      push_job.last     = flush_last;
      push_job.nbinds   = slots_used;
      push_job.total    = index_total;
    end else begin
      push_job.last   = 1'b1;
      push_job.pos_x  = item.pos_x;
      push_job.pos_y  = item.pos_y;
      push_job.size_x = item.size_x;
      push_job.size_y = item.size_y;
      push_job.color  = textured ? '0 : item.color_rgba;
      push_job.slot   = slot_sel;
    end
  end

  // The fill count never passes the table size.
  a_slots_bound: assert property (@(posedge clk) disable iff (rst)
    slots_used <= qbvg_pkg::slot_cnt_t'(qbvg_pkg::SLOT_COUNT))
    else $error("slot fill count beyond table size");

  // A quad is only queued with a slot that lies inside the filled table.
  a_slot_filled: assert property (@(posedge clk) disable iff (rst)
    (state == F_QUAD) |-> (6'(slots_used) >= slot_sel))
    else $error("quad slot beyond filled table");

endmodule

// File: hdl/qbvg_back.sv
// ----------------------------------------------------------------------------
// qbvg_back: result generation
// Takes jobs from the queue and emits bind and draw results for a flush, or
// the four corner vertices of a quad, one result per cycle into the output
// register while that register is free.
// ----------------------------------------------------------------------------
module qbvg_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 empty,
  input  qbvg_pkg::job_t       pop_job,
  output logic                 pop,
  output qbvg_pkg::back_stat_t back_stat,
  input  logic [31:0]          table_data,
  output logic                 result_valid,
  input  logic                 result_ready,
  output qbvg_pkg::result_t    result
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_BIND = 4'b0010,
    B_DRAW = 4'b0100,
    B_VERT = 4'b1000
  } back_state_t;

  back_state_t          state;
  qbvg_pkg::job_t       job;
  qbvg_pkg::slot_cnt_t  bind_idx;
  logic [1:0]           corner;
  logic                 adv;
  logic                 up;
  logic                 vp;
  qbvg_pkg::result_t    res_next;

  // Corner = floor((2 * pos +/- size) / 2), saturated to 32 bits.
  function automatic logic [31:0] corner_of(input logic [31:0] p, input logic [31:0] s,
                                            input logic plus);
    logic [33:0] pe;
    logic [33:0] se;
    logic [33:0] twice;
    logic [32:0] half;
    pe    = {p[31], p, 1'b0};
    se    = {{2{s[31]}}, s};
    twice = plus ? (pe + se) : (pe - se);
    half  = twice[33:1];
    if (half[32] != half[31]) begin
      corner_of = half[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      corner_of = half[31:0];
    end
  endfunction

  assign adv               = !result_valid || result_ready;
  assign pop               = (state == B_IDLE) && !empty;
  assign back_stat.busy    = (state != B_IDLE);
  assign back_stat.rd_addr = bind_idx[qbvg_pkg::SLOT_IDX_W-1:0];

  // Corner order (-,-), (+,-), (+,+), (-,+).
  assign up = (corner == 2'd1) || (corner == 2'd2);
  assign vp = corner[1];

  // Next result; fields that do not belong to the kind stay zero.
  always_comb begin
    res_next = '0;
    case (state)
      B_BIND: begin
        res_next.kind          = qbvg_pkg::KIND_BIND;
        res_next.slot          = 6'(bind_idx);
        res_next.bound_texture = table_data;
      end
      B_DRAW: begin
        res_next.kind          = qbvg_pkg::KIND_DRAW;
        res_next.batch_indices = job.total;
        res_next.last          = job.last;
      end
      B_VERT: begin
        res_next.kind      = qbvg_pkg::KIND_VERTEX;
        res_next.vert_x    = corner_of(job.pos_x, job.size_x, up);
        res_next.vert_y    = corner_of(job.pos_y, job.size_y, vp);
        res_next.tex_u     = up;
        res_next.tex_v     = vp;
        res_next.slot      = job.slot;
        res_next.out_color = job.color;
        res_next.last      = (corner == 2'd3);
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  // Sequencer and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      result_valid <= 1'b0;
    end else begin
      // When the register is free it takes a result from any producing state.
      if (adv) begin
        result_valid <= (state != B_IDLE);
      end
      case (state)
        B_IDLE: begin
          if (!empty) begin
            job      <= pop_job;
            bind_idx <= '0;
            corner   <= '0;
            if (!pop_job.is_flush) begin
              state <= B_VERT;
            end else if (pop_job.nbinds != '0) begin
              state <= B_BIND;
            end else begin
              state <= B_DRAW;
            end
          end
        end
        B_BIND: begin
          if (adv) begin
            bind_idx <= qbvg_pkg::slot_cnt_t'(bind_idx + 1'b1);
            if (qbvg_pkg::slot_cnt_t'(bind_idx + 1'b1) == job.nbinds) begin
              state <= B_DRAW;
            end
          end
        end
        B_DRAW: begin
          if (adv) begin
            state <= B_IDLE;
          end
        end
        B_VERT: begin
          if (adv) begin
            corner <= 2'(corner + 1'b1);
            if (corner == 2'd3) begin
              state <= B_IDLE;
            end
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (adv && (state != B_IDLE)) begin
      result <= res_next;
    end
  end

  // Binds only run over the slots that the flush job counted.
  a_bind_range: assert property (@(posedge clk) disable iff (rst)
    (state == B_BIND) |-> (bind_idx < job.nbinds))
    else $error("bind index beyond flushed slot count");

  // The closing vertex of a quad is the (-,+) corner.
  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.kind == qbvg_pkg::KIND_VERTEX) && result.last)
      |-> (result.tex_v && !result.tex_u))
    else $error("last vertex is not the closing corner");

  // Vertices are only produced from quad jobs.
  a_vert_job: assert property (@(posedge clk) disable iff (rst)
    (state == B_VERT) |-> !job.is_flush)
    else $error("vertex generation from a flush job");

endmodule

// File: hdl/quad_batch_vertex_generator.sv
// ----------------------------------------------------------------------------
// quad_batch_vertex_generator: sprite batch vertex generator
// Expands quad requests into corner vertices and groups textures into slots.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the quad channel (quad_valid / quad_ready / quad). A draw
// command yields four vertex results; a flush command, or a new texture that
// meets a full slot table, yields one bind result per filled slot and a draw
// result with the index count. Results leave on the result channel
// (result_valid / result_ready / result); the final result of each request
// carries last.
// Timing: an accepted request is registered and classified by the front and
// queued as a job. The back takes a job from the queue in its idle state and
// then emits one result per cycle while the output register is free; the
// front's classify loop overlaps it through the two-entry job queue, so the
// front can accept a new request before the back is through with the last.
// A flush job yields one bind result per filled slot and then the draw, and
// the front waits for the back to finish before it clears the table.
// Reset clears the slot count and the index count; the table contents need no
// clearing. When the receiver stalls the output register holds its result,
// the queue fills and the quad channel then stops accepting.
// ----------------------------------------------------------------------------
module quad_batch_vertex_generator (
  input  logic               clk,
  input  logic               rst,
  input  logic               quad_valid,
  output logic               quad_ready,
  input  qbvg_pkg::quad_t    quad,
  output logic               result_valid,
  input  logic               result_ready,
  output qbvg_pkg::result_t  result
);

  logic                 push;
  qbvg_pkg::job_t       push_job;
  logic                 full;
  logic                 pop;
  qbvg_pkg::job_t       pop_job;
  logic                 empty;
  qbvg_pkg::back_stat_t back_stat;
  logic [31:0]          table_data;

  // Intake and slot table.
  qbvg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .quad_valid (quad_valid),
    .quad_ready (quad_ready),
    .quad       (quad),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .empty      (empty),
    .back_stat  (back_stat),
    .table_data (table_data)
  );

  // Job queue.
  qbvg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  // Result generation.
  qbvg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .pop_job      (pop_job),
    .pop          (pop),
    .back_stat    (back_stat),
    .table_data   (table_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// File: bench/qbvg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbvg_checker: result checker for the quad batch vertex generator
// Watches both channels, keeps its own copy of the slot table and index count,
// works out the results each accepted request should cause, and compares every
// accepted result field by field with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module qbvg_checker
  import qbvg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    quad_valid,
  input  logic    quad_ready,
  input  quad_t   quad,
  input  logic    result_valid,
  input  logic    result_ready,
  input  result_t result,
  output int      errors,
  output int      pending,
  output int      checked,
  output int      binds_checked,
  output int      table_full_flushes
);

  // Shadow of the block's batch state.
  logic [31:0] slot_texture [SLOT_COUNT];
  int          slots_filled;
  int          index_sum;
  result_t     expected_results [$];

  // Running counts, published to the testbench top once per clock.
  int mismatch_count;
  int checked_count;
  int bind_count;
  int full_flush_count;

  // One corner coordinate: floor((2 * centre +/- extent) / 2), saturated.
  function automatic logic signed [31:0] corner_coord(input logic signed [31:0] centre,
                                                      input logic signed [31:0] extent,
                                                      input logic plus);
    longint twice;
    longint half;
    twice = 2 * longint'(centre) + (plus ? longint'(extent) : -longint'(extent));
    half  = twice >>> 1;
    if (half > longint'(32'sh7FFFFFFF)) half = longint'(32'sh7FFFFFFF);
    if (half < longint'(32'sh80000000)) half = longint'(32'sh80000000);
    return half[31:0];
  endfunction

  // Close the batch: one bind per filled slot, then the draw with the count.
  task automatic close_batch();
    result_t r;
    int      i;
    for (i = 0; i < slots_filled; i++) begin
      r               = '0;
      r.kind          = KIND_BIND;
      r.slot          = 6'(i);
      r.bound_texture = slot_texture[i];
      expected_results.insert(expected_results.size(), r);
    end
    r               = '0;
    r.kind          = KIND_DRAW;
    r.batch_indices = idx_t'(index_sum);
    expected_results.insert(expected_results.size(), r);
    slots_filled = 0;
    index_sum    = 0;
  endtask

  // Work out every result caused by one request and queue them in order.
  task automatic predict_request(input quad_t q);
    result_t     r;
    logic [5:0]  slot_no;
    logic [31:0] colour;
    int          hit;
    int          i;
    if (q.cmd == CMD_FLUSH) begin
      close_batch();
    end else begin
      slot_no = '0;
      colour  = q.color_rgba;
      if (q.tex_handle != '0) begin
        hit = -1;
        for (i = 0; i < slots_filled; i++) begin
          if (hit < 0 && slot_texture[i] == q.tex_handle) hit = i;
        end
        if (hit >= 0) begin
          slot_no = 6'(hit + 1);
        end else begin
          // A new texture that meets a full table closes the batch first.
          if (slots_filled >= SLOT_COUNT) begin
            close_batch();
            full_flush_count++;
          end
          slot_texture[slots_filled] = q.tex_handle;
          slots_filled++;
          slot_no = 6'(slots_filled);
        end
        colour = '0;
      end
      // Corners in the order (-,-), (+,-), (+,+), (-,+).
      for (i = 0; i < 4; i++) begin
        r           = '0;
        r.kind      = KIND_VERTEX;
        r.tex_u     = (i == 1 || i == 2);
        r.tex_v     = (i >= 2);
        r.vert_x    = corner_coord(q.pos_x, q.size_x, r.tex_u);
        r.vert_y    = corner_coord(q.pos_y, q.size_y, r.tex_v);
        r.slot      = slot_no;
        r.out_color = colour;
        expected_results.insert(expected_results.size(), r);
      end
      index_sum = (index_sum + IDX_STEP > IDX_CAP) ? IDX_CAP : index_sum + IDX_STEP;
    end
    // The final result of the request carries last.
    r      = expected_results.pop_back();
    r.last = 1'b1;
    expected_results.insert(expected_results.size(), r);
  endtask

  // Report one field and return 1 if it differs.
  function automatic int field_differs(input string fname, input logic [31:0] want,
                                       input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: result %0d field %s expected %h, got %h", $time, checked_count,
               fname, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Compare one accepted result with the oldest expectation.
  task automatic check_result(input result_t got);
    result_t want;
    int      bad;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result %h, expected none", $time, got);
      mismatch_count++;
    end else begin
      want = expected_results.pop_front();
      bad  = field_differs("kind", 32'(want.kind), 32'(got.kind));
      bad += field_differs("vert_x", want.vert_x, got.vert_x);
      bad += field_differs("vert_y", want.vert_y, got.vert_y);
      bad += field_differs("tex_u", 32'(want.tex_u), 32'(got.tex_u));
      bad += field_differs("tex_v", 32'(want.tex_v), 32'(got.tex_v));
      bad += field_differs("slot", 32'(want.slot), 32'(got.slot));
      bad += field_differs("out_color", want.out_color, got.out_color);
      bad += field_differs("bound_texture", want.bound_texture, got.bound_texture);
      bad += field_differs("batch_indices", 32'(want.batch_indices), 32'(got.batch_indices));
      bad += field_differs("last", 32'(want.last), 32'(got.last));
      mismatch_count += bad;
      checked_count++;
      if (want.kind == KIND_BIND) bind_count++;
    end
  endtask

  // Both channels are sampled at the rising edge; the request goes in first.
  always @(posedge clk) begin
    if (rst) begin
      slots_filled = 0;
      index_sum    = 0;
      expected_results.delete();
    end else begin
      if (quad_valid && quad_ready) predict_request(quad);
      if (result_valid && result_ready) check_result(result);
    end
    errors             <= mismatch_count;
    pending            <= expected_results.size();
    checked            <= checked_count;
    binds_checked      <= bind_count;
    table_full_flushes <= full_flush_count;
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the quad batch vertex generator
// Drives a directed set of quads and flushes, then random batches that reuse,
// add and overflow texture slots, with bursty requests and a stalling
// receiver. The checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module tb;
  import qbvg_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int RANDOM_ITEMS = 134;
  localparam int DRAIN_CYCLES = 50;
  localparam int CYCLE_LIMIT  = 500000;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    quad_valid   = 1'b0;
  logic    quad_ready;
  quad_t   quad         = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  int errors;
  int pending;
  int checked;
  int binds_checked;
  int table_full_flushes;

  int cycle_count = 0;
  int burst_left  = 4;
  bit idle_on     = 1'b1;
  int stall_left  = 0;
  int quads_sent  = 0;
  int flushes_sent = 0;

  // Texture ids handed out so far, for reuse within and across batches.
  logic [31:0] texture_pool [$];

  always #HALF_PERIOD clk = ~clk;

  quad_batch_vertex_generator u_top (
    .clk          (clk),
    .rst          (rst),
    .quad_valid   (quad_valid),
    .quad_ready   (quad_ready),
    .quad         (quad),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  qbvg_checker u_checker (
    .clk                (clk),
    .rst                (rst),
    .quad_valid         (quad_valid),
    .quad_ready         (quad_ready),
    .quad               (quad),
    .result_valid       (result_valid),
    .result_ready       (result_ready),
    .result             (result),
    .errors             (errors),
    .pending            (pending),
    .checked            (checked),
    .binds_checked      (binds_checked),
    .table_full_flushes (table_full_flushes)
  );

  // Cycle counter with a hard limit on the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count,
               pending);
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: quiet windows alternate with windows of random stalls.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else if (cycle_count[9:8] != 2'b00 && $urandom_range(0, 99) < 30) begin
      stall_left = $urandom_range(0, 11);
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  function automatic quad_t make_quad(input logic cmd, input logic signed [31:0] px,
                                      input logic signed [31:0] py,
                                      input logic signed [31:0] sx,
                                      input logic signed [31:0] sy,
                                      input logic [31:0] colour, input logic [31:0] tid);
    quad_t q;
    q.cmd        = cmd;
    q.pos_x      = px;
    q.pos_y      = py;
    q.size_x     = sx;
    q.size_y     = sy;
    q.color_rgba = colour;
    q.tex_handle = tid;
    return q;
  endfunction

  // A Q16.16 value: full random, small, extreme or moderate.
  function automatic logic signed [31:0] rand_q16();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      2: begin
        case ($urandom_range(0, 4))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return -1;
          3: return 0;
          default: return 1;
        endcase
      end
      default: return 32'(int'($urandom_range(0, 1 << 27)) - (1 << 26));
    endcase
  endfunction

  // Texture id: untextured, a known id, or a fresh non-zero id.
  function automatic logic [31:0] pick_texture(input int fresh_pct);
    logic [31:0] id;
    if ($urandom_range(0, 99) < 20) return '0;
    if (texture_pool.size() != 0 && $urandom_range(0, 99) >= fresh_pct)
      return texture_pool[$urandom_range(0, texture_pool.size() - 1)];
    do id = $urandom; while (id == '0);
    texture_pool.insert(texture_pool.size(), id);
    if (texture_pool.size() > 64) void'(texture_pool.pop_front());
    return id;
  endfunction

  // Present one request, hold it until accepted, then maybe leave a gap.
  task automatic send(input quad_t q);
    quad       <= q;
    quad_valid <= 1'b1;
    do @(posedge clk); while (!quad_ready);
    if (q.cmd == CMD_FLUSH) flushes_sent++;
    else quads_sent++;
    @(negedge clk);
    if (idle_on && burst_left == 0) begin
      quad_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  initial begin
    int phase_len;
    int fresh_pct;
    int phase_no;
    int sent;

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty flush, extremes of position and size, odd sizes, then
    // textured quads with a repeated id, a flush with binds and an empty flush.
    send(make_quad(CMD_FLUSH, 0, 0, 0, 0, '0, '0));
    send(make_quad(CMD_DRAW, 0, 0, 0, 0, 32'hFFFFFFFF, '0));
    send(make_quad(CMD_DRAW, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 32'h12345678, '0));
    send(make_quad(CMD_DRAW, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 32'h00000000, '0));
    send(make_quad(CMD_DRAW, Q_MAX, Q_MIN, Q_MIN, Q_MAX, 32'hA5A5A5A5, '0));
    send(make_quad(CMD_DRAW, Q_MIN, Q_MAX, Q_MAX, Q_MIN, 32'h5A5A5A5A, '0));
    send(make_quad(CMD_DRAW, -1, 1, 1, -1, 32'hFF0000FF, '0));
    send(make_quad(CMD_DRAW, 32'sh00018000, -32'sh00018000, 3, -3, 32'h00FF00FF, '0));
    send(make_quad(CMD_DRAW, 32'sh00010000, 32'sh00020000, 32'sh00040000, 32'sh00040000,
                   32'hFFFFFFFF, 32'hFFFFFFFF));
    send(make_quad(CMD_DRAW, 0, 0, 32'sh00010000, 32'sh00010000, 32'h11223344, 32'h1));
    send(make_quad(CMD_DRAW, 5, -5, 7, 9, 32'h55667788, 32'hFFFFFFFF));
    send(make_quad(CMD_DRAW, -7, 7, -9, 9, 32'h99AABBCC, 32'h80000000));
    send(make_quad(CMD_DRAW, 100, 200, 300, 400, 32'hDEADBEEF, '0));
    send(make_quad(CMD_DRAW, -100, -200, 301, 401, 32'hCAFEF00D, 32'h1));
    send(make_quad(CMD_FLUSH, 0, 0, 0, 0, '0, '0));
    send(make_quad(CMD_FLUSH, -1, -1, -1, -1, 32'hFFFFFFFF, 32'hFFFFFFFF));

    // Random batches; the first one adds enough new textures to overflow
    // the slot table, and some batches run with no gaps between requests.
    phase_no = 0;
    sent     = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len = (phase_no == 0) ? 60 : $urandom_range(1, 45);
      fresh_pct = (phase_no == 0) ? 100 : $urandom_range(0, 100);
      idle_on   = (phase_no % 4 != 1);
      repeat (phase_len) begin
        if (sent < RANDOM_ITEMS) begin
          send(make_quad(CMD_DRAW, rand_q16(), rand_q16(), rand_q16(), rand_q16(),
                         $urandom, pick_texture(fresh_pct)));
          sent++;
        end
      end
      if (sent < RANDOM_ITEMS && $urandom_range(0, 99) < 60) begin
        send(make_quad(CMD_FLUSH, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom));
        sent++;
      end
      phase_no++;
    end
    quad_valid <= 1'b0;

    // Wait for every expected result, then allow the block to settle.
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d quads and %0d flushes; checked %0d results, %0d of them binds.",
             quads_sent, flushes_sent, checked, binds_checked);
    $display("Slot table overflowed %0d times; %0d mismatches found.", table_full_flushes,
             errors);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
